// ===== design/lqe_pkg.sv =====
// Shared widths and codes for the line quad expander.
// No dependencies; used by the square root and divider pipelines and the top level.
package lqe_pkg;

	localparam int COORD_W = 32;
	localparam int WID_W   = 31;
	localparam int LANES   = 3;
	localparam int MAG_W   = 30;
	localparam int RAD_W   = 62;
	localparam int ROOT_W  = 31;
	localparam int NUM_W   = 62;
	localparam int DEN_W   = 32;
	localparam int QUO_W   = 31;

	typedef enum logic [1:0] {
		CORNER_START_PLUS = 2'd0,
		CORNER_END_PLUS   = 2'd1,
		CORNER_END_MINUS  = 2'd2,
		CORNER_START_MINUS = 2'd3
	} corner_t;

endpackage

// ===== design/lqe_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on lqe_pkg for the radicand and root widths.
module lqe_isqrt #(
	parameter int SIDE_W = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lqe_pkg::RAD_W-1:0]     in_rad,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lqe_pkg::ROOT_W-1:0]    out_root,
	output logic [SIDE_W-1:0]             out_side
);

	localparam int STEPS = lqe_pkg::ROOT_W;
	localparam int REM_W = lqe_pkg::ROOT_W + 2;

	logic                         v_s    [0:STEPS-1];
	logic                         rdy    [0:STEPS-1];
	logic [lqe_pkg::RAD_W-1:0]    x_s    [0:STEPS-1];
	logic [REM_W-1:0]             rem_s  [0:STEPS-1];
	logic [lqe_pkg::ROOT_W-1:0]   root_s [0:STEPS-1];
	logic [SIDE_W-1:0]            side_s [0:STEPS-1];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic                        pv;
		logic [lqe_pkg::RAD_W-1:0]   px;
		logic [REM_W-1:0]            prem;
		logic [lqe_pkg::ROOT_W-1:0]  proot;
		logic [SIDE_W-1:0]           pside;
		logic [REM_W+1:0]            t;
		logic [REM_W+1:0]            trial;
		logic                        ge;

		if (i == 0) begin : g_first
			assign pv    = in_valid;
			assign px    = in_rad;
			assign prem  = '0;
			assign proot = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_s[i-1];
			assign px    = x_s[i-1];
			assign prem  = rem_s[i-1];
			assign proot = root_s[i-1];
			assign pside = side_s[i-1];
		end

		if (i == STEPS - 1) begin : g_rlast
			assign rdy[i] = !v_s[i] || out_ready;
		end else begin : g_rmid
			assign rdy[i] = !v_s[i] || rdy[i+1];
		end

		assign t     = {prem, px[lqe_pkg::RAD_W-1 -: 2]};
		assign trial = (REM_W+2)'({proot, 2'b01});
		assign ge    = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				v_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i]) begin
				x_s[i]    <= {px[lqe_pkg::RAD_W-3:0], 2'b00};
				rem_s[i]  <= ge ? REM_W'(t - trial) : REM_W'(t);
				root_s[i] <= {proot[lqe_pkg::ROOT_W-2:0], ge};
				side_s[i] <= pside;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[STEPS-1];
	assign out_root  = root_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

// ===== design/lqe_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on lqe_pkg for lane count and operand widths.
module lqe_div #(
	parameter int SIDE_W = 8
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              in_valid,
	output logic                                              in_ready,
	input  logic [lqe_pkg::LANES-1:0][lqe_pkg::NUM_W-1:0]     in_num,
	input  logic [lqe_pkg::DEN_W-1:0]                         in_den,
	input  logic [SIDE_W-1:0]                                 in_side,
	output logic                                              out_valid,
	input  logic                                              out_ready,
	output logic [lqe_pkg::LANES-1:0][lqe_pkg::QUO_W-1:0]     out_quo,
	output logic [SIDE_W-1:0]                                 out_side
);

	localparam int STEPS = lqe_pkg::QUO_W;
	localparam int LO_W  = lqe_pkg::QUO_W;
	localparam int RW    = lqe_pkg::DEN_W;

	typedef logic [lqe_pkg::LANES-1:0][RW-1:0]                  rem_t;
	typedef logic [lqe_pkg::LANES-1:0][LO_W-1:0]                low_t;
	typedef logic [lqe_pkg::LANES-1:0][lqe_pkg::QUO_W-1:0]      quo_t;

	logic                        v_s    [0:STEPS-1];
	logic                        rdy    [0:STEPS-1];
	rem_t                        rem_s  [0:STEPS-1];
	low_t                        low_s  [0:STEPS-1];
	quo_t                        quo_s  [0:STEPS-1];
	logic [lqe_pkg::DEN_W-1:0]   den_s  [0:STEPS-1];
	logic [SIDE_W-1:0]           side_s [0:STEPS-1];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic                       pv;
		rem_t                       prem;
		low_t                       plow;
		quo_t                       pquo;
		logic [lqe_pkg::DEN_W-1:0]  pden;
		logic [SIDE_W-1:0]          pside;
		rem_t                       nrem;
		low_t                       nlow;
		quo_t                       nquo;

		if (i == 0) begin : g_first
			for (genvar l = 0; l < lqe_pkg::LANES; l++) begin : g_init
				assign prem[l] = RW'(in_num[l][lqe_pkg::NUM_W-1:LO_W]);
				assign plow[l] = in_num[l][LO_W-1:0];
			end
			assign pv    = in_valid;
			assign pquo  = '0;
			assign pden  = in_den;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_s[i-1];
			assign prem  = rem_s[i-1];
			assign plow  = low_s[i-1];
			assign pquo  = quo_s[i-1];
			assign pden  = den_s[i-1];
			assign pside = side_s[i-1];
		end

		if (i == STEPS - 1) begin : g_rlast
			assign rdy[i] = !v_s[i] || out_ready;
		end else begin : g_rmid
			assign rdy[i] = !v_s[i] || rdy[i+1];
		end

		always_comb begin
			logic [RW:0] t;
			logic        ge;
			nrem = '0;
			nlow = '0;
			nquo = '0;
			for (int l = 0; l < lqe_pkg::LANES; l++) begin
				t       = {prem[l], plow[l][LO_W-1]};
				ge      = t >= {1'b0, pden};
				nrem[l] = ge ? RW'(t - {1'b0, pden}) : RW'(t);
				nlow[l] = {plow[l][LO_W-2:0], 1'b0};
				nquo[l] = {pquo[l][lqe_pkg::QUO_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				v_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i]) begin
				rem_s[i]  <= nrem;
				low_s[i]  <= nlow;
				quo_s[i]  <= nquo;
				den_s[i]  <= pden;
				side_s[i] <= pside;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[STEPS-1];
	assign out_quo   = quo_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

// ===== design/line_quad_expander.sv =====
// Top level of the line quad expander: segment in, four billboard corners out.
// Depends on lqe_pkg, lqe_isqrt and lqe_div.
//
// Each accepted segment beat yields four corner beats (start+n, end+n, end-n,
// start-n, tlast on the fourth); a segment whose start equals its end yields
// none. The sustained rate is set by the four output beats per segment;
// segments can enter on consecutive cycles and queue in the pipeline.
// From input beat to first corner a segment passes twelve arithmetic stages,
// a 31-stage square root, a 31-stage divider, the corner hold register and
// the output register.
module line_quad_expander (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, width(31), eye_x, eye_y, eye_z, pad
	input  logic [319:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y, pos_z
	output logic [95:0]  m_tdata,
	// corner
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	localparam int CW = lqe_pkg::COORD_W;
	localparam int MW = lqe_pkg::MAG_W;
	localparam int L  = lqe_pkg::LANES;

	typedef logic signed [CW-1:0] coord_t;
	typedef coord_t [L-1:0]       vec_t;
	typedef logic [MW-1:0]        mag_t;

	typedef struct packed {
		vec_t                    s;
		vec_t                    e;
		logic [lqe_pkg::WID_W-1:0] w;
		mag_t [L-1:0]            pm;
		logic [L-1:0]            neg;
	} sq_side_t;

	typedef struct packed {
		vec_t         s;
		vec_t         e;
		logic         lzero;
		logic [L-1:0] neg;
	} dv_side_t;

	localparam int SQ_SIDE_W = $bits(sq_side_t);
	localparam int DV_SIDE_W = $bits(dv_side_t);

	// input fields
	vec_t                      in_s;
	vec_t                      in_e;
	vec_t                      in_eye;
	logic [lqe_pkg::WID_W-1:0] in_w;
	logic                      in_zero;

	assign in_s[0]   = s_tdata[31:0];
	assign in_s[1]   = s_tdata[63:32];
	assign in_s[2]   = s_tdata[95:64];
	assign in_e[0]   = s_tdata[127:96];
	assign in_e[1]   = s_tdata[159:128];
	assign in_e[2]   = s_tdata[191:160];
	assign in_w      = s_tdata[222:192];
	assign in_eye[0] = s_tdata[254:223];
	assign in_eye[1] = s_tdata[286:255];
	assign in_eye[2] = s_tdata[318:287];
	assign in_zero   = (in_s == in_e);

	// stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7, r_s8, r_s9, r_s10, r_s11, r_s12;

	vec_t s_s1, e_s1, s_s2, e_s2, s_s3, e_s3, s_s4, e_s4, s_s5, e_s5;
	vec_t s_s6, e_s6, s_s7, e_s7, s_s8, e_s8, s_s9, e_s9;
	vec_t s_s10, e_s10, s_s11, e_s11, s_s12, e_s12;
	logic [lqe_pkg::WID_W-1:0] w_s1, w_s2, w_s3, w_s4, w_s5, w_s6, w_s7, w_s8, w_s9;

	logic signed [32:0] d_s1 [L];
	logic signed [34:0] c_s1 [L];
	logic [31:0]        dm_s2 [L];
	logic [33:0]        cm_s2 [L];
	logic [L-1:0]       dn_s2, cn_s2;
	logic [1:0]         dsh_s2;
	logic [2:0]         csh_s2;
	logic signed [30:0] dv_s3 [L];
	logic signed [30:0] cv_s3 [L];
	logic signed [61:0] pra_s4 [L];
	logic signed [61:0] prb_s4 [L];
	logic signed [61:0] p_s5 [L];
	logic [60:0]        pmf_s6 [L];
	logic [L-1:0]       pn_s6, pn_s7, pn_s8, pn_s9;
	logic [4:0]         psh_s6;
	mag_t [L-1:0]       pm_s7, pm_s8, pm_s9;
	logic [59:0]        sq_s8 [L];
	logic [lqe_pkg::RAD_W-1:0] sum_s9;

	logic [L-1:0]       pn_s10, pn_s11;
	logic [60:0]        mw_s10 [L];
	logic [lqe_pkg::ROOT_W-1:0] root_s10;
	logic               lz_s10, lz_s11;
	logic [L-1:0][lqe_pkg::NUM_W-1:0] num_s11;
	logic [lqe_pkg::DEN_W-1:0]        den_s11;
	vec_t               off_s12;

	// square root and divider
	logic                        sq_in_ready, sq_out_valid;
	logic [lqe_pkg::ROOT_W-1:0]  sq_root;
	sq_side_t                    sq_in_side, sq_out_side;
	logic                        dv_in_ready, dv_out_valid;
	logic [L-1:0][lqe_pkg::QUO_W-1:0] dv_quo;
	dv_side_t                    dv_in_side, dv_out_side;

	// hold and output
	logic            hold_v_q, hold_rdy, load_out;
	vec_t            hold_s_q, hold_e_q, hold_off_q;
	lqe_pkg::corner_t k_q;
	logic            out_v_q;
	vec_t            out_pos_q;
	lqe_pkg::corner_t out_k_q;

	assign r_s12 = !v_s12 || hold_rdy;
	assign r_s11 = !v_s11 || dv_in_ready;
	assign r_s10 = !v_s10 || r_s11;
	assign r_s9  = !v_s9  || sq_in_ready;
	assign r_s8  = !v_s8  || r_s9;
	assign r_s7  = !v_s7  || r_s8;
	assign r_s6  = !v_s6  || r_s7;
	assign r_s5  = !v_s5  || r_s6;
	assign r_s4  = !v_s4  || r_s5;
	assign r_s3  = !v_s3  || r_s4;
	assign r_s2  = !v_s2  || r_s3;
	assign r_s1  = !v_s1  || r_s2;
	assign s_tready = r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			if (r_s1)  v_s1  <= s_tvalid && !in_zero;
			if (r_s2)  v_s2  <= v_s1;
			if (r_s3)  v_s3  <= v_s2;
			if (r_s4)  v_s4  <= v_s3;
			if (r_s5)  v_s5  <= v_s4;
			if (r_s6)  v_s6  <= v_s5;
			if (r_s7)  v_s7  <= v_s6;
			if (r_s8)  v_s8  <= v_s7;
			if (r_s9)  v_s9  <= v_s8;
			if (r_s10) v_s10 <= sq_out_valid;
			if (r_s11) v_s11 <= v_s10;
			if (r_s12) v_s12 <= dv_out_valid;
		end
	end

	// stage 1: direction and doubled camera vector
	always_ff @(posedge clk) begin
		if (r_s1) begin
			s_s1 <= in_s;
			e_s1 <= in_e;
			w_s1 <= in_w;
			for (int i = 0; i < L; i++) begin
				d_s1[i] <= 33'(in_e[i]) - 33'(in_s[i]);
				c_s1[i] <= (35'(in_eye[i]) <<< 1) - 35'(in_s[i]) - 35'(in_e[i]);
			end
		end
	end

	// stage 2: magnitudes and block shift
	always_ff @(posedge clk) begin
		logic [31:0] dor;
		logic [33:0] cor;
		if (r_s2) begin
			s_s2 <= s_s1;
			e_s2 <= e_s1;
			w_s2 <= w_s1;
			dor = '0;
			cor = '0;
			for (int i = 0; i < L; i++) begin
				dm_s2[i] <= d_s1[i][32] ? 32'(-d_s1[i]) : 32'(d_s1[i]);
				cm_s2[i] <= c_s1[i][34] ? 34'(-c_s1[i]) : 34'(c_s1[i]);
				dn_s2[i] <= d_s1[i][32];
				cn_s2[i] <= c_s1[i][34];
				dor = dor | (d_s1[i][32] ? 32'(-d_s1[i]) : 32'(d_s1[i]));
				cor = cor | (c_s1[i][34] ? 34'(-c_s1[i]) : 34'(c_s1[i]));
			end
			priority if (dor[31]) dsh_s2 <= 2'd2;
			else if (dor[30])     dsh_s2 <= 2'd1;
			else                  dsh_s2 <= 2'd0;
			priority if (cor[33]) csh_s2 <= 3'd4;
			else if (cor[32])     csh_s2 <= 3'd3;
			else if (cor[31])     csh_s2 <= 3'd2;
			else if (cor[30])     csh_s2 <= 3'd1;
			else                  csh_s2 <= 3'd0;
		end
	end

	// stage 3: apply shift, restore sign
	always_ff @(posedge clk) begin
		logic [MW-1:0] a;
		logic [MW-1:0] b;
		if (r_s3) begin
			s_s3 <= s_s2;
			e_s3 <= e_s2;
			w_s3 <= w_s2;
			for (int i = 0; i < L; i++) begin
				a = MW'(dm_s2[i] >> dsh_s2);
				b = MW'(cm_s2[i] >> csh_s2);
				dv_s3[i] <= dn_s2[i] ? -$signed({1'b0, a}) : $signed({1'b0, a});
				cv_s3[i] <= cn_s2[i] ? -$signed({1'b0, b}) : $signed({1'b0, b});
			end
		end
	end

	// stage 4: cross product terms
	always_ff @(posedge clk) begin
		if (r_s4) begin
			s_s4 <= s_s3;
			e_s4 <= e_s3;
			w_s4 <= w_s3;
			for (int i = 0; i < L; i++) begin
				pra_s4[i] <= 62'(dv_s3[(i+1)%L]) * 62'(cv_s3[(i+2)%L]);
				prb_s4[i] <= 62'(dv_s3[(i+2)%L]) * 62'(cv_s3[(i+1)%L]);
			end
		end
	end

	// stage 5: cross product
	always_ff @(posedge clk) begin
		if (r_s5) begin
			s_s5 <= s_s4;
			e_s5 <= e_s4;
			w_s5 <= w_s4;
			for (int i = 0; i < L; i++) begin
				p_s5[i] <= pra_s4[i] - prb_s4[i];
			end
		end
	end

	// stage 6: magnitudes and block shift of the cross product
	always_ff @(posedge clk) begin
		logic [60:0] por;
		logic [4:0]  sh;
		if (r_s6) begin
			s_s6 <= s_s5;
			e_s6 <= e_s5;
			w_s6 <= w_s5;
			por = '0;
			for (int i = 0; i < L; i++) begin
				pmf_s6[i] <= p_s5[i][61] ? 61'(-p_s5[i]) : 61'(p_s5[i]);
				pn_s6[i]  <= p_s5[i][61];
				por = por | (p_s5[i][61] ? 61'(-p_s5[i]) : 61'(p_s5[i]));
			end
			sh = '0;
			for (int b = MW; b < 61; b++) begin
				if (por[b]) sh = 5'(b - MW + 1);
			end
			psh_s6 <= sh;
		end
	end

	// stage 7: apply shift
	always_ff @(posedge clk) begin
		if (r_s7) begin
			s_s7  <= s_s6;
			e_s7  <= e_s6;
			w_s7  <= w_s6;
			pn_s7 <= pn_s6;
			for (int i = 0; i < L; i++) begin
				pm_s7[i] <= MW'(pmf_s6[i] >> psh_s6);
			end
		end
	end

	// stage 8: squares
	always_ff @(posedge clk) begin
		if (r_s8) begin
			s_s8  <= s_s7;
			e_s8  <= e_s7;
			w_s8  <= w_s7;
			pn_s8 <= pn_s7;
			pm_s8 <= pm_s7;
			for (int i = 0; i < L; i++) begin
				sq_s8[i] <= 60'(pm_s7[i]) * 60'(pm_s7[i]);
			end
		end
	end

	// stage 9: sum of squares
	always_ff @(posedge clk) begin
		if (r_s9) begin
			s_s9   <= s_s8;
			e_s9   <= e_s8;
			w_s9   <= w_s8;
			pn_s9  <= pn_s8;
			pm_s9  <= pm_s8;
			sum_s9 <= lqe_pkg::RAD_W'(sq_s8[0]) + lqe_pkg::RAD_W'(sq_s8[1])
				+ lqe_pkg::RAD_W'(sq_s8[2]);
		end
	end

	assign sq_in_side.s   = s_s9;
	assign sq_in_side.e   = e_s9;
	assign sq_in_side.w   = w_s9;
	assign sq_in_side.pm  = pm_s9;
	assign sq_in_side.neg = pn_s9;

	lqe_isqrt #(
		.SIDE_W (SQ_SIDE_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.in_ready  (sq_in_ready),
		.in_rad    (sum_s9),
		.in_side   (sq_in_side),
		.out_valid (sq_out_valid),
		.out_ready (r_s10),
		.out_root  (sq_root),
		.out_side  (sq_out_side)
	);

	// stage 10: scale magnitudes by width
	always_ff @(posedge clk) begin
		if (r_s10) begin
			s_s10    <= sq_out_side.s;
			e_s10    <= sq_out_side.e;
			pn_s10   <= sq_out_side.neg;
			root_s10 <= sq_root;
			lz_s10   <= (sq_root == '0);
			for (int i = 0; i < L; i++) begin
				mw_s10[i] <= 61'(sq_out_side.pm[i]) * 61'(sq_out_side.w);
			end
		end
	end

	// stage 11: rounding term and divisor
	always_ff @(posedge clk) begin
		if (r_s11) begin
			s_s11   <= s_s10;
			e_s11   <= e_s10;
			pn_s11  <= pn_s10;
			lz_s11  <= lz_s10;
			den_s11 <= {root_s10, 1'b0};
			for (int i = 0; i < L; i++) begin
				num_s11[i] <= lqe_pkg::NUM_W'(mw_s10[i]) + lqe_pkg::NUM_W'(root_s10);
			end
		end
	end

	assign dv_in_side.s     = s_s11;
	assign dv_in_side.e     = e_s11;
	assign dv_in_side.lzero = lz_s11;
	assign dv_in_side.neg   = pn_s11;

	lqe_div #(
		.SIDE_W (DV_SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s11),
		.in_ready  (dv_in_ready),
		.in_num    (num_s11),
		.in_den    (den_s11),
		.in_side   (dv_in_side),
		.out_valid (dv_out_valid),
		.out_ready (r_s12),
		.out_quo   (dv_quo),
		.out_side  (dv_out_side)
	);

	// stage 12: signed offset
	always_ff @(posedge clk) begin
		logic signed [CW-1:0] q;
		if (r_s12) begin
			s_s12 <= dv_out_side.s;
			e_s12 <= dv_out_side.e;
			for (int i = 0; i < L; i++) begin
				q = $signed(CW'(dv_quo[i]));
				if (dv_out_side.lzero)       off_s12[i] <= '0;
				else if (dv_out_side.neg[i]) off_s12[i] <= -q;
				else                         off_s12[i] <= q;
			end
		end
	end

	// corner sequencing
	assign load_out = hold_v_q && (!out_v_q || m_tready);
	assign hold_rdy = !hold_v_q || (load_out && k_q == lqe_pkg::CORNER_START_MINUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			k_q      <= lqe_pkg::CORNER_START_PLUS;
			out_v_q  <= 1'b0;
		end else begin
			if (hold_rdy) hold_v_q <= v_s12;
			if (load_out) begin
				unique case (k_q)
					lqe_pkg::CORNER_START_PLUS:  k_q <= lqe_pkg::CORNER_END_PLUS;
					lqe_pkg::CORNER_END_PLUS:    k_q <= lqe_pkg::CORNER_END_MINUS;
					lqe_pkg::CORNER_END_MINUS:   k_q <= lqe_pkg::CORNER_START_MINUS;
					lqe_pkg::CORNER_START_MINUS: k_q <= lqe_pkg::CORNER_START_PLUS;
					default:                     k_q <= lqe_pkg::CORNER_START_PLUS;
				endcase
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold_rdy) begin
			hold_s_q   <= s_s12;
			hold_e_q   <= e_s12;
			hold_off_q <= off_s12;
		end
	end

	// corner position with saturation
	always_ff @(posedge clk) begin
		logic                 use_start;
		logic                 plus;
		logic signed [CW:0]   sum;
		if (load_out) begin
			use_start = (k_q == lqe_pkg::CORNER_START_PLUS)
				|| (k_q == lqe_pkg::CORNER_START_MINUS);
			plus = (k_q == lqe_pkg::CORNER_START_PLUS) || (k_q == lqe_pkg::CORNER_END_PLUS);
			for (int i = 0; i < L; i++) begin
				if (plus) sum = (CW+1)'(use_start ? hold_s_q[i] : hold_e_q[i])
					+ (CW+1)'(hold_off_q[i]);
				else      sum = (CW+1)'(use_start ? hold_s_q[i] : hold_e_q[i])
					- (CW+1)'(hold_off_q[i]);
				if (sum[CW] != sum[CW-1])
					out_pos_q[i] <= sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
				else
					out_pos_q[i] <= sum[CW-1:0];
			end
			out_k_q <= k_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_pos_q[2], out_pos_q[1], out_pos_q[0]};
	assign m_tuser  = out_k_q;
	assign m_tlast  = (out_k_q == lqe_pkg::CORNER_START_MINUS);

endmodule
